// ===== design/sbo_pkg.sv =====
// Shared types, codes and helpers for the sparse block occupancy octree mask.
`timescale 1ns / 1ps
`default_nettype none
package sbo_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [2:0] CFG_GRID_X     = 3'd0;
    localparam logic [2:0] CFG_GRID_Y     = 3'd1;
    localparam logic [2:0] CFG_GRID_Z     = 3'd2;
    localparam logic [2:0] CFG_BLOCK_SIZE = 3'd3;
    localparam logic [2:0] CFG_THRESHOLD  = 3'd4;

    localparam int WORD_BITS = 64;

    // One step of the shared subtract/compare unit.
    typedef struct packed {
        logic       ge;
        logic [6:0] rem;
        logic [5:0] quo;
    } div_res_t;

    // Absolute value that saturates the most negative code.
    function automatic logic signed [31:0] sat_abs(input logic signed [31:0] v);
        logic signed [31:0] r;
        begin
            if (v == 32'sh8000_0000)
                r = 32'sh7FFF_FFFF;
            else if (v < 0)
                r = -v;
            else
                r = v;
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/sbo_divstep.sv =====
// Shared subtract/compare unit: one restoring step of a division by block size.
`timescale 1ns / 1ps
`default_nettype none
module sbo_divstep (
    input  wire logic [6:0]       num,
    input  wire logic [3:0]       den,
    input  wire logic [5:0]       quo,
    output sbo_pkg::div_res_t     res
);
    import sbo_pkg::*;

    logic [6:0] diff;

    assign diff    = num - {3'b000, den};
    assign res.ge  = (num >= {3'b000, den});
    assign res.rem = res.ge ? diff : num;
    assign res.quo = res.ge ? quo + 6'd1 : quo;

endmodule
`default_nettype wire

// ===== design/sbo_store.sv =====
// Occupancy word memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module sbo_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [63:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [63:0]   rdata
);
    import sbo_pkg::*;

    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/sparse_block_occupancy_octree_mask.sv =====
// Top level: sequencer, configuration registers and query walker for the occupancy store.
//
// Usage. Pulse start with command and its fields while busy is low; the
// transaction is taken at that edge. A load (command 0) sets or clears one
// cell's bit and gives no result. A query (command 1) gives one child_mask
// on a one-cycle done strobe; the receiver cannot stall, so take it then.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
// Writing grid_x, grid_y, grid_z or block_size restarts a clearing pass.
// Division. One subtract/compare unit divides by the block size, one step
// per cycle, for three axes in turn. A load writes nothing when the
// in-block bit index reaches 64 or a block index is out of range, and is
// not taken when the cell lies outside the grid. A query walks len^3 blocks,
// len being 1 for extent 0 or 1 and 2*floor(extent/2) otherwise, each block
// going through the single memory read port in states QA, QRD and QCHK.
// Reset. Reset, and each layout write, runs a clearing pass over all
// MAX_BLOCKS_PER_AXIS^3 words (4096 by default) with busy high.
`timescale 1ns / 1ps
`default_nettype none
module sparse_block_occupancy_octree_mask #(
    parameter int MAX_GRID_CELLS      = 32,
    parameter int MAX_BLOCKS_PER_AXIS = 16,
    parameter int BLOCK_MASK_BITS     = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               command,
    input  wire logic [5:0]         cell_x,
    input  wire logic [5:0]         cell_y,
    input  wire logic [5:0]         cell_z,
    input  wire logic signed [31:0] density,
    input  wire logic signed [31:0] x_velocity,
    input  wire logic signed [5:0]  min_block_x,
    input  wire logic signed [5:0]  min_block_y,
    input  wire logic signed [5:0]  min_block_z,
    input  wire logic [5:0]         extent,
    output logic                    done,
    output logic [7:0]              child_mask,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import sbo_pkg::*;

    localparam int DEPTH = MAX_BLOCKS_PER_AXIS * MAX_BLOCKS_PER_AXIS * MAX_BLOCKS_PER_AXIS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_DIV   = 11'b000_0000_0100,
        S_IDX1  = 11'b000_0000_1000,
        S_IDX2  = 11'b000_0001_0000,
        S_LRD   = 11'b000_0010_0000,
        S_LWR   = 11'b000_0100_0000,
        S_QINIT = 11'b000_1000_0000,
        S_QA    = 11'b001_0000_0000,
        S_QRD   = 11'b010_0000_0000,
        S_QCHK  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [5:0]         grid_reg [3];
    logic [3:0]         bsize_reg;
    logic signed [31:0] thr_reg;
    logic               cfg_wr, cfg_layout;

    // Effective layout
    logic [3:0] beff;
    logic [5:0] geff [3];
    logic [5:0] cin  [3];

    // Latched transaction
    logic               qmode_reg;
    logic [5:0]         c_reg   [3];
    logic signed [5:0]  mb_reg  [3];
    logic               hit_reg;
    logic               small_reg;
    logic [4:0]         half_reg;
    logic [5:0]         len_reg;

    // Divider sequencing
    logic [6:0] num_reg;
    logic [5:0] quo_reg;
    logic [1:0] axis_reg;
    logic [5:0] q_reg [3];
    logic [2:0] r_reg [3];
    div_res_t   dres;
    logic [6:0] num_first, num_after;

    // Load index path
    logic [6:0]    t_reg;
    logic [AW-1:0] p_reg;
    logic [AW-1:0] addr_reg;
    logic [9:0]    bit_reg;
    logic          oor_reg;

    // Query walker
    logic [7:0]        n_reg   [3];
    logic [5:0]        i_reg   [3];
    logic signed [7:0] coord   [3];
    logic [2:0]        inr;
    logic              inr_reg;
    logic [2:0]        oct_reg;
    logic [6:0]        xq_reg;
    logic [7:0]        mask_reg, mask_next;
    logic              last_blk;

    // Clearing pass
    logic [AW-1:0] clr_reg;

    // Memory ports
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [63:0]   mem_wdata, mem_rdata, bit_mask;

    logic done_reg;
    logic [7:0] child_mask_reg;
    logic load_ok;

    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign cfg_layout = cfg_wr && (cfg_index == CFG_GRID_X || cfg_index == CFG_GRID_Y ||
                                   cfg_index == CFG_GRID_Z || cfg_index == CFG_BLOCK_SIZE);
    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign child_mask = child_mask_reg;

    // Clamp block size to 2..8 and grid counts to the supported maximum.
    assign beff = (bsize_reg < 4'd2) ? 4'd2 : ((bsize_reg > 4'd8) ? 4'd8 : bsize_reg);
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            geff[k] = (int'(grid_reg[k]) > MAX_GRID_CELLS) ? 6'(MAX_GRID_CELLS) : grid_reg[k];
        end
    end

    assign cin[0] = cell_x;
    assign cin[1] = cell_y;
    assign cin[2] = cell_z;

    // Drop loads whose cell lies outside the interior grid.
    always_comb
    begin
        load_ok = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            if (cin[k] == 6'd0 || cin[k] > geff[k])
                load_ok = 1'b0;
        end
    end

    // Dividend for an axis: cell offset on loads, ceiling form of grid on queries.
    function automatic logic [6:0] dividend(input logic qm, input logic [5:0] c,
                                            input logic [5:0] g, input logic [3:0] b);
        logic [6:0] v;
        begin
            if (qm == CMD_QUERY)
                v = {1'b0, g} + {3'b000, b} - 7'd1;
            else
                v = {1'b0, c} - 7'd1;
            return v;
        end
    endfunction

    assign num_first = dividend(command, cell_x, geff[0], beff);
    assign num_after = (axis_reg == 2'd0) ? dividend(qmode_reg, c_reg[1], geff[1], beff)
                                          : dividend(qmode_reg, c_reg[2], geff[2], beff);

    sbo_divstep u_div (
        .num (num_reg),
        .den (beff),
        .quo (quo_reg),
        .res (dres)
    );

    // Query block coordinates and range test.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            coord[k] = 8'(mb_reg[k]) + $signed({2'b00, i_reg[k]});
            inr[k]   = (coord[k] >= 0) && (coord[k] < $signed(n_reg[k]));
        end
    end

    assign last_blk = (i_reg[0] == len_reg - 6'd1) && (i_reg[1] == len_reg - 6'd1) &&
                      (i_reg[2] == len_reg - 6'd1);

    always_comb
    begin
        mask_next = mask_reg;
        if (inr_reg && mem_rdata != 64'd0)
            mask_next = small_reg ? 8'hFF : (mask_reg | (8'd1 << oct_reg));
    end

    // Memory port steering.
    assign bit_mask = 64'd1 << bit_reg[5:0];
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = hit_reg ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
        mem_re    = 1'b0;
        mem_raddr = addr_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = 64'd0;
        end
        else if (state_reg == S_LWR)
        begin
            mem_we = 1'b1;
        end
        if (state_reg == S_LRD)
        begin
            mem_re = 1'b1;
        end
        else if (state_reg == S_QRD)
        begin
            mem_re    = inr_reg;
            mem_raddr = AW'(xq_reg) + AW'(MAX_BLOCKS_PER_AXIS) * p_reg;
        end
    end

    sbo_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start && (command == CMD_QUERY || load_ok))
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!dres.ge && axis_reg == 2'd2)
                    state_next = (qmode_reg == CMD_QUERY) ? S_QINIT : S_IDX1;
            end
            S_IDX1:  state_next = S_IDX2;
            S_IDX2:  state_next = S_LRD;
            S_LRD:
            begin
                if (oor_reg || int'(bit_reg) >= BLOCK_MASK_BITS)
                    state_next = S_IDLE;
                else
                    state_next = S_LWR;
            end
            S_LWR:   state_next = S_IDLE;
            S_QINIT: state_next = S_QA;
            S_QA:    state_next = S_QRD;
            S_QRD:   state_next = S_QCHK;
            S_QCHK:  state_next = last_blk ? S_IDLE : S_QA;
            default: state_next = S_IDLE;
        endcase
        // A layout write wipes the store, whatever is under way.
        if (cfg_layout)
            state_next = S_CLEAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            grid_reg[0] <= 6'd32;
            grid_reg[1] <= 6'd32;
            grid_reg[2] <= 6'd32;
            bsize_reg   <= 4'd4;
            thr_reg     <= '0;
            clr_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_QCHK) && last_blk && !cfg_layout;
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    CFG_GRID_X:     grid_reg[0] <= cfg_data[5:0];
                    CFG_GRID_Y:     grid_reg[1] <= cfg_data[5:0];
                    CFG_GRID_Z:     grid_reg[2] <= cfg_data[5:0];
                    CFG_BLOCK_SIZE: bsize_reg   <= cfg_data[3:0];
                    CFG_THRESHOLD:  thr_reg     <= $signed(cfg_data);
                    default:        ;
                endcase
            end
            if (cfg_layout)
                clr_reg <= '0;
            else if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + AW'(1);
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                qmode_reg <= command;
                c_reg[0]  <= cell_x;
                c_reg[1]  <= cell_y;
                c_reg[2]  <= cell_z;
                mb_reg[0] <= min_block_x;
                mb_reg[1] <= min_block_y;
                mb_reg[2] <= min_block_z;
                hit_reg   <= (sat_abs(density) > thr_reg) || (sat_abs(x_velocity) > thr_reg);
                small_reg <= (extent <= 6'd1);
                half_reg  <= extent[5:1];
                len_reg   <= (extent <= 6'd1) ? 6'd1 : {extent[5:1], 1'b0};
                num_reg   <= num_first;
                quo_reg   <= '0;
                axis_reg  <= 2'd0;
            end
            S_DIV:
            begin
                if (dres.ge)
                begin
                    num_reg <= dres.rem;
                    quo_reg <= dres.quo;
                end
                else
                begin
                    q_reg[axis_reg] <= quo_reg;
                    r_reg[axis_reg] <= num_reg[2:0];
                    axis_reg        <= axis_reg + 2'd1;
                    num_reg         <= num_after;
                    quo_reg         <= '0;
                end
            end
            S_IDX1:
            begin
                t_reg   <= 7'(r_reg[1]) + 7'(beff) * 7'(r_reg[2]);
                p_reg   <= AW'(q_reg[1]) + AW'(MAX_BLOCKS_PER_AXIS) * AW'(q_reg[2]);
                oor_reg <= (int'(q_reg[0]) >= MAX_BLOCKS_PER_AXIS) ||
                           (int'(q_reg[1]) >= MAX_BLOCKS_PER_AXIS) ||
                           (int'(q_reg[2]) >= MAX_BLOCKS_PER_AXIS);
            end
            S_IDX2:
            begin
                bit_reg  <= 10'(r_reg[0]) + 10'(beff) * 10'(t_reg);
                addr_reg <= AW'(q_reg[0]) + AW'(MAX_BLOCKS_PER_AXIS) * p_reg;
            end
            S_QINIT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (q_reg[k] == 6'd0)
                        n_reg[k] <= 8'd1;
                    else if (int'(q_reg[k]) > MAX_BLOCKS_PER_AXIS)
                        n_reg[k] <= 8'(MAX_BLOCKS_PER_AXIS);
                    else
                        n_reg[k] <= {2'b00, q_reg[k]};
                    i_reg[k] <= '0;
                end
                mask_reg <= '0;
            end
            S_QA:
            begin
                inr_reg <= &inr;
                xq_reg  <= coord[0][6:0];
                p_reg   <= AW'(coord[1][6:0]) + AW'(MAX_BLOCKS_PER_AXIS) * AW'(coord[2][6:0]);
                for (int k = 0; k < 3; k++)
                begin
                    oct_reg[k] <= (i_reg[k] >= {1'b0, half_reg});
                end
            end
            S_QCHK:
            begin
                mask_reg <= mask_next;
                if (last_blk)
                    child_mask_reg <= mask_next;
                // Advance x fastest, then y, then z.
                if (i_reg[0] != len_reg - 6'd1)
                    i_reg[0] <= i_reg[0] + 6'd1;
                else
                begin
                    i_reg[0] <= '0;
                    if (i_reg[1] != len_reg - 6'd1)
                        i_reg[1] <= i_reg[1] + 6'd1;
                    else
                    begin
                        i_reg[1] <= '0;
                        i_reg[2] <= i_reg[2] + 6'd1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/sbo_checker.sv =====
// Port-level checker for the occupancy octree mask, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sbo_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic command,
    input wire logic done
);
    import sbo_pkg::*;

    // A result only closes out work that was under way.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without preceding busy");

    // A load transaction never yields a result right behind it.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_LOAD) |=> !done)
        else $error("result after load");

    // Results come one transaction at a time.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back done");

    // A query taken in idle starts work.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_QUERY) |=> busy)
        else $error("query did not start");

endmodule

bind sparse_block_occupancy_octree_mask sbo_checker u_sbo_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .command (command),
    .done    (done)
);
`default_nettype wire
